>>> rtl/alist_pkg.sv
// Shared constants, types and codes for the array list engine.
package alist_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_DELETE    = 3'd2,
    REQ_READ      = 3'd3,
    REQ_OVERWRITE = 3'd4,
    REQ_REMOVE    = 3'd5
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Operands for the shared compare / step unit
  typedef struct packed {
    cmp_t  a;
    cmp_t  b;
    cnt_t  cur;
    data_t data_a;
    data_t data_b;
  } unit_req_t;

  // Results from the shared compare / step unit
  typedef struct packed {
    logic lt;
    logic eq;
    cnt_t up;
    cnt_t dn;
    logic data_eq;
  } unit_res_t;

endpackage

>>> rtl/alist_if.sv
// Request and response channel interfaces for the array list engine.
interface alist_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [alist_pkg::REQ_W-1:0]            req_type;
  logic signed [alist_pkg::DATA_W-1:0]    value;
  logic [alist_pkg::POS_W-1:0]            position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface alist_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [alist_pkg::STATUS_W-1:0]         status;
  logic signed [alist_pkg::DATA_W-1:0]    read_value;
  logic [alist_pkg::COUNT_W-1:0]          entry_count;
  logic                                   is_full;
  logic                                   is_empty;

  modport source (output valid, status, read_value, entry_count, is_full, is_empty,
                  input ready);
  modport sink   (input valid, status, read_value, entry_count, is_full, is_empty,
                  output ready);
endinterface

>>> rtl/alist_store.sv
// Entry store: one write port, one read port with registered read data.
module alist_store (
  input  logic             clk,
  input  logic             we,
  input  alist_pkg::addr_t waddr,
  input  alist_pkg::data_t wdata,
  input  alist_pkg::addr_t raddr,
  output alist_pkg::data_t rdata
);
  import alist_pkg::*;

  data_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/alist_unit.sv
// Shared unit: position compare, cursor step and entry equality.
module alist_unit (
  input  alist_pkg::unit_req_t op,
  output alist_pkg::unit_res_t res
);
  import alist_pkg::*;

  always_comb begin
    res.lt      = (op.a < op.b);
    res.eq      = (op.a == op.b);
    res.up      = op.cur + CNT_W'(1);
    res.dn      = op.cur - CNT_W'(1);
    res.data_eq = (op.data_a == op.data_b);
  end

endmodule

>>> rtl/array_list_engine_core.sv
// Array list engine: ordered list of up to CAPACITY entries, one request at a time.
// Append, insert at the end, overwrite, unused codes and refusals go straight to the finish step;
// read passes through a read step, insert inside the list shifts the entries up, delete shifts
// them down, and removal scans for the value, then shifts the later entries down on a hit.
// Ready in idle only, so requests are sequential; a response not yet taken adds its stall.
// Reset clears the count, sequencer and response valid; the store is not cleared.
module array_list_engine_core (
  input  logic        clk,
  input  logic        rst,
  alist_req_if.sink   req,
  alist_rsp_if.source rsp
);
  import alist_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_UP   = 6'b000100,
    S_DOWN = 6'b001000,
    S_SCAN = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t    state;
  cnt_t      total;
  cnt_t      cur;
  addr_t     tag;
  logic      pend;
  cmp_t      pos_q;
  data_t     val_q;
  data_t     rd_q;
  status_t   st_q;

  logic                 out_valid;
  status_t              out_status;
  data_t                out_read;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_full;
  logic                 out_empty;

  logic      mem_we;
  addr_t     mem_waddr;
  data_t     mem_wdata;
  addr_t     mem_raddr;
  data_t     mem_rdata;

  unit_req_t uop;
  unit_res_t ures;

  req_code_t req_code;
  cmp_t      pos_in;
  cmp_t      total_c;
  logic      full;

  assign req_code = req_code_t'(req.req_type);
  assign pos_in   = CMP_W'(req.position);
  assign total_c  = CMP_W'(total);
  assign full     = (total == CNT_W'(CAPACITY));

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_read;
  assign rsp.entry_count = out_count;
  assign rsp.is_full     = out_full;
  assign rsp.is_empty    = out_empty;

  alist_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  alist_unit u_unit (
    .op  (uop),
    .res (ures)
  );

  // operand select for the shared unit
  always_comb begin
    uop.a      = pos_in;
    uop.b      = total_c;
    uop.cur    = cur;
    uop.data_a = mem_rdata;
    uop.data_b = val_q;
    if (state == S_UP) begin
      uop.a = pos_q;
      uop.b = CMP_W'(cur);
    end else if (state == S_DOWN || state == S_SCAN) begin
      uop.a = CMP_W'(cur);
      uop.b = total_c;
    end
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tag;
    mem_wdata = mem_rdata;
    mem_raddr = cur[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req_code == REQ_APPEND && !full) begin
            mem_we    = 1'b1;
            mem_waddr = total[ADDR_W-1:0];
            mem_wdata = req.value;
          end else if (req_code == REQ_OVERWRITE && ures.lt) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(req.position);
            mem_wdata = req.value;
          end else if (req_code == REQ_INSERT && !full && ures.eq) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(req.position);
            mem_wdata = req.value;
          end
          mem_raddr = ADDR_W'(req.position);
        end
      end
      S_UP: begin
        mem_raddr = ures.dn[ADDR_W-1:0];
        if (pend) begin
          mem_we = 1'b1;
        end else if (!ures.lt) begin
          // gap opened: drop the new entry in
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(pos_q);
          mem_wdata = val_q;
        end
      end
      S_DOWN: begin
        mem_we = pend;
      end
      S_READ, S_SCAN, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            val_q <= req.value;
            pos_q <= pos_in;
            rd_q  <= '0;
            pend  <= 1'b0;
            unique case (req_code)
              REQ_APPEND: begin
                state <= S_FIN;
                if (full) begin
                  st_q <= ST_FULL;
                end else begin
                  st_q  <= ST_OK;
                  total <= total + CNT_W'(1);
                end
              end
              REQ_INSERT: begin
                if (full) begin
                  st_q  <= ST_FULL;
                  state <= S_FIN;
                end else if (!ures.lt && !ures.eq) begin
                  st_q  <= ST_RANGE;
                  state <= S_FIN;
                end else if (ures.eq) begin
                  st_q  <= ST_OK;
                  total <= total + CNT_W'(1);
                  state <= S_FIN;
                end else begin
                  st_q  <= ST_OK;
                  cur   <= total;
                  state <= S_UP;
                end
              end
              REQ_DELETE: begin
                if (!ures.lt) begin
                  st_q  <= ST_RANGE;
                  state <= S_FIN;
                end else begin
                  st_q  <= ST_OK;
                  cur   <= CNT_W'(req.position) + CNT_W'(1);
                  state <= S_DOWN;
                end
              end
              REQ_READ: begin
                if (!ures.lt) begin
                  st_q  <= ST_RANGE;
                  state <= S_FIN;
                end else begin
                  st_q  <= ST_OK;
                  state <= S_READ;
                end
              end
              REQ_OVERWRITE: begin
                st_q  <= ures.lt ? ST_OK : ST_RANGE;
                state <= S_FIN;
              end
              REQ_REMOVE: begin
                st_q  <= ST_NOTFOUND;
                cur   <= '0;
                state <= S_SCAN;
              end
              default: begin
                st_q  <= ST_OK;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_READ: begin
          rd_q  <= mem_rdata;
          state <= S_FIN;
        end
        // shift up, walking down from the end
        S_UP: begin
          if (ures.lt) begin
            pend <= 1'b1;
            tag  <= cur[ADDR_W-1:0];
            cur  <= ures.dn;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            total <= total + CNT_W'(1);
            state <= S_FIN;
          end
        end
        // shift down, walking up from the hole
        S_DOWN: begin
          if (ures.lt) begin
            pend <= 1'b1;
            tag  <= ures.dn[ADDR_W-1:0];
            cur  <= ures.up;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            total <= total - CNT_W'(1);
            state <= S_FIN;
          end
        end
        // search; on a hit cur already points one past the match
        S_SCAN: begin
          if (pend && ures.data_eq) begin
            pend  <= 1'b0;
            st_q  <= ST_OK;
            state <= S_DOWN;
          end else if (ures.lt) begin
            pend <= 1'b1;
            tag  <= cur[ADDR_W-1:0];
            cur  <= ures.up;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= st_q;
            out_read   <= rd_q;
            out_count  <= COUNT_W'(total);
            out_full   <= full;
            out_empty  <= (total == '0);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response register only fills from the finish step
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("response raised outside finish step");

  // count stays within capacity
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // count moves by at most one per cycle
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (total == $past(total) || total == $past(total) + CNT_W'(1) ||
              total == $past(total) - CNT_W'(1)))
    else $error("entry count jumped");

  // pending store transfer only inside a walk
  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_UP || state == S_DOWN || state == S_SCAN))
    else $error("pending store transfer outside a walk");

endmodule

>>> test/tb_array_list_engine_core.sv
// Self-checking testbench for the array list engine: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_array_list_engine_core;
  import alist_pkg::*;

  // Request codes the block must ignore
  localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

  localparam int RANDOM_REQS  = 1660;
  localparam int CALM_TAIL    = 200;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    data_t               read_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_full;
    logic                is_empty;
  } list_rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0] code;
    data_t            val;
    logic [POS_W-1:0] pos;
    int               reps;
    logic             pinned;
    status_t          st;
    data_t            rd;
    int               cnt;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst;

  alist_req_if req_ch ();
  alist_rsp_if rsp_ch ();

  array_list_engine_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list
  data_t       shadow_entries [CAPACITY];
  int unsigned shadow_total;

  list_rsp_t   pending_rsp [$];
  probe_row_t  plan [$];

  int  mismatches;
  int  reqs_sent;
  int  rsps_checked;
  int  full_hits;
  int  empty_hits;
  int  quiet_cycles;
  bit  calm;
  bit  long_hold_due;

  // Close the gap left by the entry at idx
  function automatic void drop_entry(int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < shadow_total; i++)
      shadow_entries[i] = shadow_entries[i + 1];
    shadow_total--;
  endfunction

  // Apply one request to the shadow list and return the response it must give
  function automatic list_rsp_t apply_list_op(logic [REQ_W-1:0] code, data_t val,
                                              logic [POS_W-1:0] pos);
    list_rsp_t   r;
    int unsigned p;
    int unsigned i;
    bit          hit;
    p            = pos;
    hit          = 1'b0;
    r.status     = ST_OK;
    r.read_value = '0;
    case (code)
      REQ_APPEND: begin
        if (shadow_total >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_total] = val;
          shadow_total++;
        end
      end
      REQ_INSERT: begin
        if (shadow_total >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p > shadow_total) begin
          r.status = ST_RANGE;
        end else begin
          for (i = shadow_total; i > p; i--)
            shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[p] = val;
          shadow_total++;
        end
      end
      REQ_DELETE: begin
        if (p >= shadow_total) r.status = ST_RANGE;
        else drop_entry(p);
      end
      REQ_READ: begin
        if (p >= shadow_total) r.status = ST_RANGE;
        else r.read_value = shadow_entries[p];
      end
      REQ_OVERWRITE: begin
        if (p >= shadow_total) r.status = ST_RANGE;
        else shadow_entries[p] = val;
      end
      REQ_REMOVE: begin
        for (i = 0; i < shadow_total && !hit; i++) begin
          if (shadow_entries[i] == val) begin
            drop_entry(i);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(shadow_total);
    r.is_full     = (shadow_total == CAPACITY);
    r.is_empty    = (shadow_total == 0);
    return r;
  endfunction

  function automatic probe_row_t probe(logic [REQ_W-1:0] code, data_t val,
                                       logic [POS_W-1:0] pos, int reps, logic pinned,
                                       status_t st, data_t rd, int cnt);
    probe_row_t row;
    row.code   = code;
    row.val    = val;
    row.pos    = pos;
    row.reps   = reps;
    row.pinned = pinned;
    row.st     = st;
    row.rd     = rd;
    row.cnt    = cnt;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH t=%0t rsp %0d %s: got 0x%0h, want 0x%0h",
               $time, rsps_checked, what, got, want);
  endtask

  // Offer one request; on transfer, queue the response it must give
  task automatic offer(input logic [REQ_W-1:0] code, input data_t val,
                       input logic [POS_W-1:0] pos, input logic pinned,
                       input list_rsp_t pinned_rsp);
    list_rsp_t predicted;
    if (!calm && ((reqs_sent / 40) % 3 != 0) && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= code;
    req_ch.value    <= val;
    req_ch.position <= pos;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_list_op(code, val, pos);
    pending_rsp.push_back(pinned ? pinned_rsp : predicted);
    reqs_sent++;
  endtask

  // Sender stays quiet until every outstanding response has come back
  task automatic drain_outstanding();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Response side: random stalls, one long hold-off on request
  initial begin : rsp_stall_gen
    int loops;
    loops = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      loops++;
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && ((loops / 300) % 3 != 0) && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Response check against the oldest outstanding expectation
  always @(posedge clk) begin : rsp_check
    list_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsps_checked++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with none outstanding", 32'(rsp_ch.status), 32'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (want.is_full) full_hits++;
        if (want.is_empty) empty_hits++;
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.read_value !== want.read_value)
          report_mismatch("read_value", rsp_ch.read_value, want.read_value);
        if (rsp_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp_ch.entry_count), 32'(want.entry_count));
        if (rsp_ch.is_full !== want.is_full)
          report_mismatch("is_full", 32'(rsp_ch.is_full), 32'(want.is_full));
        if (rsp_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp_ch.is_empty), 32'(want.is_empty));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
               quiet_cycles, pending_rsp.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Main stimulus
  initial begin : stimulus
    list_rsp_t        pinned_rsp;
    list_rsp_t        none_rsp;
    logic [REQ_W-1:0] code;
    data_t            val;
    int               pos_top;
    int               pos;
    int               roll;
    int               k;
    int               rep;
    int               n;
    bit               growing;

    mismatches    = 0;
    reqs_sent     = 0;
    rsps_checked  = 0;
    full_hits     = 0;
    empty_hits    = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    long_hold_due = 1'b0;
    none_rsp      = '0;
    shadow_total  = 0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;

    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_APPEND;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: refusals on an empty list, extremes, every code, full list
    plan.push_back(probe(REQ_READ,      32'h0,        4'd0,  1, 1'b1, ST_RANGE,    '0, 0));
    plan.push_back(probe(REQ_DELETE,    32'h0,        4'd0,  1, 1'b1, ST_RANGE,    '0, 0));
    plan.push_back(probe(REQ_OVERWRITE, 32'h1,        4'd0,  1, 1'b1, ST_RANGE,    '0, 0));
    plan.push_back(probe(REQ_REMOVE,    32'h0,        4'd0,  1, 1'b1, ST_NOTFOUND, '0, 0));
    plan.push_back(probe(REQ_INSERT,    32'h9,        4'd1,  1, 1'b1, ST_RANGE,    '0, 0));
    plan.push_back(probe(REQ_INSERT,    32'h7FFFFFFF, 4'd0,  1, 1'b1, ST_OK,       '0, 1));
    plan.push_back(probe(REQ_READ,      32'h0,        4'd0,  1, 1'b1, ST_OK, 32'h7FFFFFFF, 1));
    plan.push_back(probe(REQ_APPEND,    32'h80000000, 4'd0,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_APPEND,    32'hFFFFFFFF, 4'd15, 1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_INSERT,    32'h0,        4'd3,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_INSERT,    32'h5,        4'd1,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_READ,      32'h0,        4'd1,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_OVERWRITE, 32'h12345678, 4'd4,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_REMOVE,    32'h80000000, 4'd0,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_REMOVE,    32'h0BADF00D, 4'd0,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_DELETE,    32'h0,        4'd0,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_DELETE,    32'h0,        4'd2,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_RSVD_LO,   32'h55555555, 4'd0,  1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_RSVD_HI,   32'hFFFFFFFF, 4'd15, 1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_APPEND,    32'h100,      4'd0, 14, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_APPEND,    32'h1,        4'd0,  1, 1'b1, ST_FULL,     '0, 16));
    plan.push_back(probe(REQ_INSERT,    32'h2,        4'd0,  1, 1'b1, ST_FULL,     '0, 16));
    plan.push_back(probe(REQ_READ,      32'h0,        4'd15, 1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_OVERWRITE, 32'hAAAAAAAA, 4'd15, 1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_DELETE,    32'h0,        4'd15, 1, 1'b0, ST_OK,       '0, 0));
    plan.push_back(probe(REQ_READ,      32'h0,        4'd15, 1, 1'b1, ST_RANGE,    '0, 15));

    for (k = 0; k < plan.size(); k++) begin
      pinned_rsp.status      = plan[k].st;
      pinned_rsp.read_value  = plan[k].rd;
      pinned_rsp.entry_count = COUNT_W'(plan[k].cnt);
      pinned_rsp.is_full     = (plan[k].cnt == CAPACITY);
      pinned_rsp.is_empty    = (plan[k].cnt == 0);
      for (rep = 0; rep < plan[k].reps; rep++)
        offer(plan[k].code, plan[k].val + data_t'(rep), plan[k].pos, plan[k].pinned,
              pinned_rsp);
    end
    drain_outstanding();

    // Random traffic: alternate growing and shrinking phases to visit full and empty
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == 300) long_hold_due = 1'b1;
      if (n == 900) drain_outstanding();
      if (n == RANDOM_REQS - CALM_TAIL) calm = 1'b1;
      growing = ((n / 60) % 2 == 0);

      roll = $urandom_range(0, 99);
      if (roll < 5)       code = (roll < 3) ? REQ_RSVD_LO : REQ_RSVD_HI;
      else if (roll < 18) code = REQ_READ;
      else if (roll < 30) code = REQ_OVERWRITE;
      else if (roll < 55) code = growing ? REQ_APPEND : REQ_DELETE;
      else if (roll < 80) code = growing ? REQ_INSERT : REQ_REMOVE;
      else if (roll < 90) code = growing ? REQ_DELETE : REQ_APPEND;
      else                code = growing ? REQ_REMOVE : REQ_INSERT;

      case ($urandom_range(0, 3))
        0, 1:    val = $urandom();
        2:       val = data_t'($urandom_range(0, 7));
        default: begin
          case ($urandom_range(0, 3))
            0:       val = 32'h80000000;
            1:       val = 32'h7FFFFFFF;
            2:       val = 32'hFFFFFFFF;
            default: val = 32'h0;
          endcase
        end
      endcase
      // Removal mostly targets a value that is present
      if (code == REQ_REMOVE && shadow_total > 0 && $urandom_range(0, 3) != 0)
        val = shadow_entries[$urandom_range(0, shadow_total - 1)];

      // Positions mostly inside the list, some anywhere
      pos_top = (code == REQ_INSERT) ? int'(shadow_total) : int'(shadow_total) - 1;
      if (pos_top > 15) pos_top = 15;
      if (pos_top < 0 || $urandom_range(0, 4) == 0) pos = $urandom_range(0, 15);
      else pos = $urandom_range(0, pos_top);

      offer(code, val, POS_W'(pos), 1'b0, none_rsp);
    end

    // Wind down
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests over all six operations and both unused codes;",
             reqs_sent);
    $display("%0d responses checked, list full in %0d of them and empty in %0d.",
             rsps_checked, full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
